// ===== rtl/core/tps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;
    localparam int TableDepthDef = 65536;
    localparam int ValW = 16;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_NOT_BUILT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MUL_RD,
        S_MUL_DIV,
        S_MUL_WR,
        S_Q_DIV,
        S_Q_RD,
        S_Q_DONE,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/tps_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle
module tps_div (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [tps_pkg::ValW-1:0] dividend,
    input  wire logic [tps_pkg::ValW-1:0] dvsr,
    output logic                          busy,
    output logic [tps_pkg::ValW-1:0]      quot
);
    import tps_pkg::*;
    localparam int CntW = $clog2(ValW + 1);

    logic [ValW-1:0] rem_reg, rem_next, q_reg, q_next, d_reg, d_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [ValW:0]   trial;

    always_comb begin
        rem_next = rem_reg;
        q_next   = q_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg, q_reg[ValW-1]};
        if (start) begin
            rem_next = '0;
            q_next   = dividend;
            d_next   = dvsr;
            cnt_next = CntW'(ValW);
        end else if (cnt_reg != '0) begin
            if (trial >= {1'b0, d_reg}) begin
                rem_next = ValW'(trial - {1'b0, d_reg});
                q_next   = {q_reg[ValW-2:0], 1'b1};
            end else begin
                rem_next = trial[ValW-1:0];
                q_next   = {q_reg[ValW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;
endmodule
`default_nettype wire

// ===== rtl/core/tps_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Totient and prime tables, one port, registered read
module tps_mem #(
    parameter int TABLE_DEPTH = tps_pkg::TableDepthDef,
    parameter int AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            addr,
    input  wire logic [tps_pkg::ValW-1:0] wphi,
    input  wire logic                     wprime,
    output logic [tps_pkg::ValW-1:0]      rphi,
    output logic                          rprime
);
    import tps_pkg::*;
    logic [ValW:0] mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= {wprime, wphi};
        end
        {rprime, rphi} <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/totient_prime_sieve_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Query: the request starts the serial divide; the quotient's table entry is read once
// the divide is done, then the result is registered. Build: init writes each entry up to
// limit, then a scan checks every value; each multiple of a prime is read, divided, written.
// One request at a time; the result is held until taken and a new request waits for it.
// Synchronous active-low reset clears control and the built flag and sets limit to 65535;
// table contents are undefined until a build writes them.
module totient_prime_sieve_table #(
    parameter int TABLE_DEPTH = tps_pkg::TableDepthDef
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // number[15:0], divisor[31:16]
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // phi_value[15:0], prime_flag[16], status[18:17]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import tps_pkg::*;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int TopInt = (TABLE_DEPTH > 65536) ? 65535 : TABLE_DEPTH - 1;
    localparam logic [15:0] TopMax = 16'(TopInt);

    state_t state_reg, state_next;
    logic [15:0] limit_reg;
    logic        built_reg, built_next;
    logic [15:0] v_reg, v_next, m_reg, m_next, num_reg, num_next, div_reg, div_next;
    logic [18:0] out_reg, out_next;
    logic [15:0] top;
    logic        mul_go_reg;
    logic        pf_reg;

    // memory port
    logic          we, wprime, rprime;
    logic [AW-1:0] addr;
    logic [15:0]   wphi, rphi;
    // divider
    logic          dstart, dbusy;
    logic [15:0]   dnum, dden, dq;
    logic [16:0]   m_sum, m_first;

    assign top = (limit_reg > TopMax) ? TopMax : limit_reg;

    tps_mem #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .aclk(aclk), .we(we), .addr(addr), .wphi(wphi), .wprime(wprime),
        .rphi(rphi), .rprime(rprime)
    );

    tps_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart), .dividend(dnum),
        .dvsr(dden), .busy(dbusy), .quot(dq)
    );

    assign m_sum   = {1'b0, m_reg} + {1'b0, v_reg};
    assign m_first = {v_reg, 1'b0};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_tuser ? S_Q_DIV : S_INIT;
                end
            end
            S_INIT:     if (v_reg == top) state_next = (top < 16'd2) ? S_OUT : S_SCAN_RD;
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (rprime && m_first <= {1'b0, top}) state_next = S_MUL_RD;
                else if (v_reg == top) state_next = S_OUT;
                else state_next = S_SCAN_RD;
            end
            S_MUL_RD:   state_next = S_MUL_DIV;
            S_MUL_DIV:  if (!dstart && !dbusy) state_next = S_MUL_WR;
            S_MUL_WR: begin
                if (m_sum <= {1'b0, top}) state_next = S_MUL_RD;
                else if (v_reg == top) state_next = S_OUT;
                else state_next = S_SCAN_RD;
            end
            S_Q_DIV:    if (!dstart && !dbusy) state_next = S_Q_RD;
            S_Q_RD:     state_next = S_Q_DONE;
            S_Q_DONE:   state_next = S_OUT;
            S_OUT:      if (m_tready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        v_next = v_reg; m_next = m_reg; num_next = num_reg; div_next = div_reg;
        out_next = out_reg; built_next = built_reg;
        we = 1'b0; wphi = v_reg; wprime = 1'b1; addr = AW'(v_reg);
        dstart = 1'b0; dnum = rphi; dden = v_reg;
        case (state_reg)
            S_IDLE: begin
                num_next = s_tdata[15:0];
                div_next = s_tdata[31:16];
                v_next   = '0;
                out_next = '0;
                if (s_tvalid && s_tuser) begin
                    dstart = 1'b1;
                    dnum = s_tdata[15:0];
                    dden = (s_tdata[31:16] == '0) ? 16'd1 : s_tdata[31:16];
                end
            end
            S_INIT: begin
                we = 1'b1;
                wphi = (v_reg == '0) ? 16'd1 : v_reg;
                wprime = (v_reg > 16'd1);
                v_next = (v_reg == top) ? 16'd2 : v_reg + 16'd1;
                if (v_reg == top) built_next = 1'b1;
            end
            S_SCAN_RD: addr = AW'(v_reg);
            S_SCAN_CHK: begin
                if (rprime) begin
                    we = 1'b1; wphi = v_reg - 16'd1; wprime = 1'b1;
                end
                // first multiple of a prime is twice the prime
                if (rprime && m_first <= {1'b0, top}) m_next = m_first[15:0];
                else v_next = v_reg + 16'd1;
            end
            S_MUL_RD: addr = AW'(m_reg);
            S_MUL_DIV: begin
                // start the divide on the cycle the multiple's entry arrives
                addr = AW'(m_reg);
                dstart = mul_go_reg;
            end
            S_MUL_WR: begin
                addr = AW'(m_reg); we = 1'b1; wprime = 1'b0;
                wphi = 16'(dq * (v_reg - 16'd1));
                if (m_sum <= {1'b0, top}) m_next = m_sum[15:0];
                else v_next = v_reg + 16'd1;
            end
            // prime bit of number is read while the divide runs
            S_Q_DIV: addr = AW'(num_reg);
            S_Q_RD: addr = AW'(dq);
            S_Q_DONE: begin
                if (!built_reg) out_next = {ST_NOT_BUILT, 17'd0};
                else if (num_reg > top) out_next = {ST_RANGE, 17'd0};
                else if (div_reg == '0) out_next = {ST_DIV_ZERO, 17'd0};
                else out_next = {ST_OK, pf_reg, rphi};
            end
            default: ;
        endcase
    end

    // control, limit and built flag; data registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            built_reg  <= 1'b0;
            limit_reg  <= 16'hFFFF;
            mul_go_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            built_reg  <= (cfg_valid && cfg_ready) ? 1'b0 : built_next;
            if (cfg_valid && cfg_ready) limit_reg <= cfg_data;
            mul_go_reg <= (state_reg == S_MUL_RD);
        end
        v_reg <= v_next; m_reg <= m_next; num_reg <= num_next; div_reg <= div_next;
        out_reg <= out_next;
        if (state_reg == S_Q_RD) pf_reg <= rprime;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {5'd0, out_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> !built_reg) else $error("built survived config");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg[18:17] != ST_OK) |-> (out_reg[16:0] == '0))
        else $error("error answer carries data");
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tps_pkg::*;

    // expected answer of one request
    typedef struct packed {
        logic [15:0] phi_value;
        logic        prime_flag;
        status_t     status;
    } answer_t;

    // Totient sieve predictor and store of pending answers
    class totient_scoreboard;
        bit [15:0] phi_tab [65536];
        bit        prime_tab [65536];
        bit        built;
        int        limit;
        answer_t   pending_q[$];
        int        errors;

        function new();
            built  = 0;
            limit  = 65535;
            errors = 0;
        endfunction

        function void set_limit(input bit [15:0] val);
            limit = val;
            built = 0;
        endfunction

        function void sieve();
            int top;
            int p;
            int m;
            top = limit;
            for (int v = 0; v <= top; v++) begin
                phi_tab[v]   = 16'(v);
                prime_tab[v] = 1;
            end
            phi_tab[0]   = 1;
            prime_tab[0] = 0;
            if (top >= 1) prime_tab[1] = 0;
            for (p = 2; p <= top; p++) begin
                if (prime_tab[p]) begin
                    phi_tab[p] = 16'(p - 1);
                    for (m = 2 * p; m <= top; m += p) begin
                        prime_tab[m] = 0;
                        phi_tab[m]   = 16'((int'(phi_tab[m]) / p) * (p - 1));
                    end
                end
            end
            built = 1;
        endfunction

        // note an accepted request and queue its answer
        function void note_request(input bit func, input bit [15:0] num, input bit [15:0] dv);
            answer_t a;
            a = '{phi_value: 16'd0, prime_flag: 1'b0, status: ST_OK};
            if (!func) sieve();
            else if (!built) a.status = ST_NOT_BUILT;
            else if (num > limit) a.status = ST_RANGE;
            else if (dv == 0) a.status = ST_DIV_ZERO;
            else begin
                a.phi_value  = phi_tab[num / dv];
                a.prime_flag = prime_tab[num];
            end
            pending_q = {pending_q, a};
        endfunction

        // compare one accepted result with the oldest answer
        function void check_result(input logic [23:0] data);
            answer_t a;
            if (pending_q.size() == 0) begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            a = pending_q.pop_front();
            if (data[15:0] !== a.phi_value) begin
                $error("phi_value expected %0d actual %0d", a.phi_value, data[15:0]);
                errors++;
            end
            if (data[16] !== a.prime_flag) begin
                $error("prime_flag expected %0d actual %0d", a.prime_flag, data[16]);
                errors++;
            end
            if (data[18:17] !== a.status) begin
                $error("status expected %0d actual %0d", a.status, data[18:17]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // number[15:0], divisor[31:16]
    logic        s_tuser = 0;    // func
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;        // phi_value[15:0], prime_flag[16], status[18:17]
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    totient_scoreboard sb = new();
    int burst_left = 0;
    int rx_mode = 0;
    bit long_hold_req = 0;
    int hold_cnt = 0;

    always #5 aclk = ~aclk;

    totient_prime_sieve_table DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // result monitor and receiver stall pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (long_hold_req) begin
            long_hold_req = 0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // send one request, with bursts and gaps
    task automatic send_req(input bit func, input bit [15:0] num, input bit [15:0] dv);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {dv, num};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(func, num, dv);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_limit(input bit [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_limit(val);
        cfg_valid <= 1'b0;
    endtask

    // mostly in-range queries with a few errors and, if allow_build, rebuilds
    task automatic random_queries(input int count, input bit allow_build);
        int lim;
        int sel;
        bit [15:0] num;
        bit [15:0] dv;
        lim = sb.limit;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            num = 16'($urandom_range(0, lim));
            if (sel < 3 && allow_build) begin
                send_req(1'b0, 16'($urandom), 16'($urandom));
                continue;
            end
            if (sel < 9 && lim < 65535) num = 16'($urandom_range(lim + 1, 65535));
            sel = $urandom_range(0, 99);
            if (sel < 6) dv = 0;
            else if (sel < 50) dv = 1;
            else if (sel < 85) dv = 16'($urandom_range(1, int'(num) + 1));
            else dv = 16'($urandom);
            send_req(1'b1, num, dv);
        end
    endtask

    initial begin
        #400_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int lim;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: nothing built yet
        send_req(1'b1, 16'd0, 16'd1);
        send_req(1'b1, 16'hFFFF, 16'd0);
        // limit of one
        write_limit(16'd1);
        send_req(1'b0, 16'd0, 16'd0);
        send_req(1'b1, 16'd0, 16'd1);
        send_req(1'b1, 16'd1, 16'd1);
        send_req(1'b1, 16'd1, 16'hFFFF);
        send_req(1'b1, 16'd1, 16'd0);
        send_req(1'b1, 16'd2, 16'd0);
        send_req(1'b1, 16'hFFFF, 16'd1);
        // limit of zero covers only entry 0
        write_limit(16'd0);
        send_req(1'b1, 16'd0, 16'd1);
        send_req(1'b0, 16'hFFFF, 16'hFFFF);
        send_req(1'b1, 16'd0, 16'd1);
        send_req(1'b1, 16'd0, 16'd0);
        send_req(1'b1, 16'd1, 16'd1);
        // small table: primes, divisor above number, composite gcd
        write_limit(16'd30);
        send_req(1'b0, 16'd0, 16'd0);
        send_req(1'b1, 16'd29, 16'd1);
        send_req(1'b1, 16'd30, 16'd6);
        send_req(1'b1, 16'd12, 16'd13);
        send_req(1'b1, 16'd30, 16'd1);
        send_req(1'b1, 16'd31, 16'd1);
        send_req(1'b1, 16'd2, 16'd1);

        // random phases over several small limits
        for (int ph = 0; ph < 5; ph++) begin
            rx_mode = ph % 3;
            lim = (ph == 4) ? 1500 : $urandom_range(2, 1200);
            write_limit(16'(lim));
            send_req(1'b1, 16'($urandom_range(0, lim)), 16'd1);
            send_req(1'b0, 16'd0, 16'd0);
            if (ph == 1) long_hold_req = 1;
            random_queries(120, 1'b1);
            if (ph == 2) drain();
            random_queries(120, 1'b1);
        end

        // largest table, built once
        rx_mode = 1;
        write_limit(16'hFFFF);
        send_req(1'b0, 16'd0, 16'd0);
        send_req(1'b1, 16'hFFFF, 16'd1);
        send_req(1'b1, 16'hFFF1, 16'd1);
        send_req(1'b1, 16'hFFFF, 16'hFFFF);
        send_req(1'b1, 16'hFFFF, 16'd0);
        random_queries(400, 1'b0);

        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
